// File: hdl/quadratic_equation_solver_unit_defines.svh
// ----------------------------------------------------------------------------
// Quadratic equation solver - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_EQUATION_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_EQUATION_SOLVER_UNIT_DEFINES_SVH

// Same-cycle implication
`define QES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/qes_pkg.sv
// ----------------------------------------------------------------------------
// qes_pkg
// Types and constants shared by the quadratic equation solver modules.
// ----------------------------------------------------------------------------
package qes_pkg;

  localparam int COEF_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int EPS_BITS   = 16;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;
  localparam int D_BITS     = 2 * COEF_BITS + 1;
  localparam int NUM_BITS   = COEF_BITS + 2;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_ANY      = 3'd1,
    KIND_LINEAR   = 3'd2,
    KIND_TWO      = 3'd3,
    KIND_DOUBLE   = 3'd4,
    KIND_NEG_DISC = 3'd5
  } kind_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
    logic signed [COEF_BITS-1:0] coef_c;
  } in_item_t;

  typedef struct packed {
    kind_t                       kind;
    logic signed [COEF_BITS-1:0] root_one;
    logic signed [COEF_BITS-1:0] root_two;
    logic                        overflow;
  } out_item_t;

  // Classified equation: roots are (base +/- isqrt(disc)) / den in sign-magnitude
  typedef struct packed {
    kind_t                kind;
    logic                 nbase;
    logic [COEF_BITS-1:0] mbase;
    logic                 nden;
    logic [COEF_BITS:0]   den;
    logic [D_BITS-1:0]    disc;
  } job_t;

endpackage

// File: hdl/qes_fifo.sv
// ----------------------------------------------------------------------------
// qes_fifo
// Short job queue between the classifying front end and the root back end.
// ----------------------------------------------------------------------------
module qes_fifo #(
  parameter int DEPTH = qes_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  qes_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output qes_pkg::job_t pop_job,
  output logic          not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qes_pkg::job_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job   = mem_r[rd_ptr_r];
  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);

endmodule

// File: hdl/qes_sqrt.sv
// ----------------------------------------------------------------------------
// qes_sqrt
// Pipelined floor square root, one result bit per stage, with side payload.
// ----------------------------------------------------------------------------
module qes_sqrt #(
  parameter int PW = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [qes_pkg::D_BITS-1:0]   in_rad,
  input  logic [PW-1:0]                in_pl,
  output logic                         out_valid,
  output logic [qes_pkg::COEF_BITS:0]  out_root,
  output logic [PW-1:0]                out_pl
);

  localparam int RW  = qes_pkg::COEF_BITS + 1;
  localparam int SW  = 2 * RW;
  localparam int RMW = RW + 3;

  logic [SW-1:0]  rad_r  [RW];
  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [PW-1:0]  pl_r   [RW];
  logic           v_r    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic           pv;
    logic [SW-1:0]  prad;
    logic [RMW-1:0] prem;
    logic [RW-1:0]  proot;
    logic [PW-1:0]  ppl;
    logic [RMW-1:0] rem_sh, trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prad  = SW'(in_rad);
      assign prem  = '0;
      assign proot = '0;
      assign ppl   = in_pl;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign prad  = rad_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign ppl   = pl_r[k-1];
    end

    assign rem_sh = {prem[RMW-3:0], prad[SW-1:SW-2]};
    assign trial  = RMW'({proot, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= prad << 2;
        rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k] <= {proot[RW-2:0], ge};
        pl_r[k]   <= ppl;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_pl    = pl_r[RW-1];

endmodule

// File: hdl/qes_div.sv
// ----------------------------------------------------------------------------
// qes_div
// Two-lane pipelined restoring divider, shared divisor, one quotient bit per
// stage; truncates toward zero and saturates to the signed coefficient range.
// ----------------------------------------------------------------------------
module qes_div #(
  parameter int FRAC_BITS = qes_pkg::FRAC_BITS,
  parameter int PW        = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic                                in_neg1,
  input  logic [qes_pkg::NUM_BITS-1:0]        in_num1,
  input  logic                                in_neg2,
  input  logic [qes_pkg::NUM_BITS-1:0]        in_num2,
  input  logic [qes_pkg::COEF_BITS:0]         in_den,
  input  logic [PW-1:0]                       in_pl,
  output logic                                out_valid,
  output logic [qes_pkg::COEF_BITS-1:0]       out_root1,
  output logic [qes_pkg::COEF_BITS-1:0]       out_root2,
  output logic                                out_ovf,
  output logic [PW-1:0]                       out_pl
);

  localparam int CB = qes_pkg::COEF_BITS;
  localparam int NW = qes_pkg::NUM_BITS + FRAC_BITS;
  localparam int DB = CB + 1;
  localparam int RB = DB + 1;

  logic [NW-1:0] n_r   [NW][2];
  logic [RB-1:0] rem_r [NW][2];
  logic [NW-1:0] q_r   [NW][2];
  logic          neg_r [NW][2];
  logic [DB-1:0] den_r [NW];
  logic [PW-1:0] pl_r  [NW];
  logic          v_r   [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          pv;
    logic [DB-1:0] pden;
    logic [PW-1:0] ppl;
    logic [NW-1:0] pn   [2];
    logic [RB-1:0] prem [2];
    logic [NW-1:0] pq   [2];
    logic          pneg [2];

    if (k == 0) begin : g_first
      assign pv      = in_valid;
      assign pden    = in_den;
      assign ppl     = in_pl;
      assign pn[0]   = NW'(in_num1) << FRAC_BITS;
      assign pn[1]   = NW'(in_num2) << FRAC_BITS;
      assign pneg[0] = in_neg1;
      assign pneg[1] = in_neg2;
      assign prem[0] = '0;
      assign prem[1] = '0;
      assign pq[0]   = '0;
      assign pq[1]   = '0;
    end else begin : g_next
      assign pv   = v_r[k-1];
      assign pden = den_r[k-1];
      assign ppl  = pl_r[k-1];
      for (genvar m = 0; m < 2; m++) begin : g_prev
        assign pn[m]   = n_r[k-1][m];
        assign prem[m] = rem_r[k-1][m];
        assign pq[m]   = q_r[k-1][m];
        assign pneg[m] = neg_r[k-1][m];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RB-1:0] rem_sh, den_x;
      logic          ge;

      assign rem_sh = {prem[l][RB-2:0], pn[l][NW-1]};
      assign den_x  = RB'(pden);
      assign ge     = (rem_sh >= den_x);

      always_ff @(posedge clk) begin
        if (en) begin
          n_r[k][l]   <= pn[l] << 1;
          rem_r[k][l] <= ge ? rem_sh - den_x : rem_sh;
          q_r[k][l]   <= {pq[l][NW-2:0], ge};
          neg_r[k][l] <= pneg[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= pden;
        pl_r[k]  <= ppl;
      end
    end
  end

  // Saturate: a negative result may reach -2^(CB-1), a positive one 2^(CB-1)-1
  localparam logic [NW-1:0] HALF = NW'(1) << (CB - 1);

  logic [CB-1:0] root_w [2];
  logic          ovf_w  [2];

  for (genvar l = 0; l < 2; l++) begin : g_sat
    logic [NW-1:0] lim, qs;
    logic          over;

    assign lim       = neg_r[NW-1][l] ? HALF : HALF - 1'b1;
    assign over      = (q_r[NW-1][l] > lim);
    assign qs        = over ? lim : q_r[NW-1][l];
    assign root_w[l] = neg_r[NW-1][l] ? CB'(~qs + 1'b1) : CB'(qs);
    assign ovf_w[l]  = over;
  end

  assign out_valid = v_r[NW-1];
  assign out_root1 = root_w[0];
  assign out_root2 = root_w[1];
  assign out_ovf   = ovf_w[0] | ovf_w[1];
  assign out_pl    = pl_r[NW-1];

endmodule

// File: hdl/qes_front.sv
// ----------------------------------------------------------------------------
// qes_front
// Front end: unpacks coefficients, forms the exact discriminant, classifies
// the equation and hands a root job to the queue.
// ----------------------------------------------------------------------------
module qes_front #(
  parameter int FRAC_BITS = qes_pkg::FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  qes_pkg::in_item_t              in_item,
  input  logic [qes_pkg::EPS_BITS-1:0]   eps,
  input  logic                           q_full,
  output logic                           job_valid,
  output qes_pkg::job_t                  job
);

  localparam int CB = qes_pkg::COEF_BITS;
  localparam int EB = qes_pkg::EPS_BITS;
  localparam int DW = qes_pkg::D_BITS;

  typedef struct packed {
    logic          na, nb, nc;
    logic [CB-1:0] ma, mb, mc;
    logic          sa, sb, sc;
    logic [EB-1:0] thr;
  } coef_t;

  logic            en;
  logic            v1_r, v2_r, v3_r;
  coef_t           s1_r, s1_nxt, s2_r, s3_r;
  logic [2*CB-1:0] bb_r, bb_nxt, p_r, p_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic            nd_r, nd_nxt;

  // Whole front end holds while its last item waits on a full queue
  assign en       = !(v3_r && q_full);
  assign in_stall = !en;

  // Stage 1: sign-magnitude and near-zero flags
  always_comb begin
    logic [CB-1:0] ra, rb, rc;
    logic [EB-1:0] thr_w;
    ra            = in_item.coef_a;
    rb            = in_item.coef_b;
    rc            = in_item.coef_c;
    thr_w         = (eps == '0) ? EB'(1) : eps;
    s1_nxt.na     = ra[CB-1];
    s1_nxt.nb     = rb[CB-1];
    s1_nxt.nc     = rc[CB-1];
    s1_nxt.ma     = ra[CB-1] ? (~ra + 1'b1) : ra;
    s1_nxt.mb     = rb[CB-1] ? (~rb + 1'b1) : rb;
    s1_nxt.mc     = rc[CB-1] ? (~rc + 1'b1) : rc;
    s1_nxt.sa     = (s1_nxt.ma < CB'(thr_w));
    s1_nxt.sb     = (s1_nxt.mb < CB'(thr_w));
    s1_nxt.sc     = (s1_nxt.mc < CB'(thr_w));
    s1_nxt.thr    = thr_w;
  end

  // Stage 2: b^2 and a*c
  assign bb_nxt = s1_r.mb * s1_r.mb;
  assign p_nxt  = s1_r.ma * s1_r.mc;

  // Stage 3: D = b^2 - 4ac in sign-magnitude
  always_comb begin
    logic [DW-1:0] bbw, p4;
    bbw = DW'(bb_r);
    p4  = {p_r[2*CB-2:0], 2'b00};
    if (s2_r.na != s2_r.nc) begin
      nd_nxt = 1'b0;
      d_nxt  = bbw + p4;
    end else if (bbw >= p4) begin
      nd_nxt = 1'b0;
      d_nxt  = bbw - p4;
    end else begin
      nd_nxt = 1'b1;
      d_nxt  = p4 - bbw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      bb_r <= bb_nxt;
      p_r  <= p_nxt;
      s3_r <= s2_r;
      d_r  <= d_nxt;
      nd_r <= nd_nxt;
    end
  end

  // Classification; D threshold carries the extra fraction bits of b^2
  logic [DW-1:0] dthr;
  assign dthr = DW'(s3_r.thr) << FRAC_BITS;

  always_comb begin
    job       = '0;
    job.den   = (CB+1)'(1);
    job.kind  = qes_pkg::KIND_NONE;
    if (s3_r.sa && s3_r.sb) begin
      job.kind = s3_r.sc ? qes_pkg::KIND_ANY : qes_pkg::KIND_NONE;
    end else if (s3_r.sa) begin
      job.kind  = qes_pkg::KIND_LINEAR;
      job.nbase = !s3_r.nc;
      job.mbase = s3_r.mc;
      job.nden  = s3_r.nb;
      job.den   = {1'b0, s3_r.mb};
    end else if (nd_r) begin
      job.kind = qes_pkg::KIND_NEG_DISC;
    end else begin
      job.nbase = !s3_r.nb;
      job.mbase = s3_r.mb;
      job.nden  = s3_r.na;
      job.den   = {s3_r.ma, 1'b0};
      if (d_r < dthr) begin
        job.kind = qes_pkg::KIND_DOUBLE;
      end else begin
        job.kind = qes_pkg::KIND_TWO;
        job.disc = d_r;
      end
    end
  end

  assign job_valid = v3_r && !q_full;

endmodule

// File: hdl/qes_back.sv
// ----------------------------------------------------------------------------
// qes_back
// Back end: square root of the discriminant, numerator forming, two-lane
// division and the result register.
// ----------------------------------------------------------------------------
module qes_back #(
  parameter int FRAC_BITS = qes_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  qes_pkg::job_t      job,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output qes_pkg::out_item_t out_item
);

  localparam int CB  = qes_pkg::COEF_BITS;
  localparam int NB  = qes_pkg::NUM_BITS;

  typedef struct packed {
    qes_pkg::kind_t kind;
    logic           nbase;
    logic [CB-1:0]  mbase;
    logic           nden;
    logic [CB:0]    den;
  } sq_pl_t;

  localparam int SPW = $bits(sq_pl_t);
  localparam int KW  = $bits(qes_pkg::kind_t);

  logic               en;
  logic               out_valid_r;
  qes_pkg::out_item_t out_item_r, out_item_nxt;

  // Whole back end advances unless a finished result is held up
  assign en      = !(out_valid_r && out_stall);
  assign job_pop = en && job_valid;

  sq_pl_t         sq_in, sq_out;
  logic [SPW-1:0] sq_out_raw;
  logic           sq_v;
  logic [CB:0]    sq_s;

  assign sq_in.kind  = job.kind;
  assign sq_in.nbase = job.nbase;
  assign sq_in.mbase = job.mbase;
  assign sq_in.nden  = job.nden;
  assign sq_in.den   = job.den;

  qes_sqrt #(.PW(SPW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (job_valid),
    .in_rad    (job.disc),
    .in_pl     (sq_in),
    .out_valid (sq_v),
    .out_root  (sq_s),
    .out_pl    (sq_out_raw)
  );

  assign sq_out = sq_pl_t'(sq_out_raw);

  // base +/- s in sign-magnitude
  logic          a_v_r;
  logic          a_neg1_r, a_neg2_r, a_neg1_nxt, a_neg2_nxt;
  logic [NB-1:0] a_num1_r, a_num2_r, a_num1_nxt, a_num2_nxt;
  logic [CB:0]   a_den_r;
  qes_pkg::kind_t a_kind_r;

  always_comb begin
    logic [NB-1:0] mx, sx;
    logic          n1, n2;
    mx = NB'(sq_out.mbase);
    sx = NB'(sq_s);
    if (!sq_out.nbase) begin
      n1 = 1'b0;
      a_num1_nxt = mx + sx;
    end else if (mx >= sx) begin
      n1 = 1'b1;
      a_num1_nxt = mx - sx;
    end else begin
      n1 = 1'b0;
      a_num1_nxt = sx - mx;
    end
    if (sq_out.nbase) begin
      n2 = 1'b1;
      a_num2_nxt = mx + sx;
    end else if (mx >= sx) begin
      n2 = 1'b0;
      a_num2_nxt = mx - sx;
    end else begin
      n2 = 1'b1;
      a_num2_nxt = sx - mx;
    end
    a_neg1_nxt = (n1 != sq_out.nden);
    a_neg2_nxt = (n2 != sq_out.nden);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg1_r <= a_neg1_nxt;
      a_neg2_r <= a_neg2_nxt;
      a_num1_r <= a_num1_nxt;
      a_num2_r <= a_num2_nxt;
      a_den_r  <= sq_out.den;
      a_kind_r <= sq_out.kind;
    end
  end

  logic          dv_v, dv_ovf;
  logic [CB-1:0] dv_r1, dv_r2;
  logic [KW-1:0] dv_kind_raw;
  qes_pkg::kind_t dv_kind;

  qes_div #(.FRAC_BITS(FRAC_BITS), .PW(KW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_v_r),
    .in_neg1   (a_neg1_r),
    .in_num1   (a_num1_r),
    .in_neg2   (a_neg2_r),
    .in_num2   (a_num2_r),
    .in_den    (a_den_r),
    .in_pl     (a_kind_r),
    .out_valid (dv_v),
    .out_root1 (dv_r1),
    .out_root2 (dv_r2),
    .out_ovf   (dv_ovf),
    .out_pl    (dv_kind_raw)
  );

  assign dv_kind = qes_pkg::kind_t'(dv_kind_raw);

  always_comb begin
    logic has_root;
    has_root = (dv_kind == qes_pkg::KIND_LINEAR) || (dv_kind == qes_pkg::KIND_TWO) ||
               (dv_kind == qes_pkg::KIND_DOUBLE);
    out_item_nxt.kind     = dv_kind;
    out_item_nxt.root_one = has_root ? dv_r1 : '0;
    out_item_nxt.root_two = has_root ? dv_r2 : '0;
    out_item_nxt.overflow = has_root && dv_ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: hdl/quadratic_equation_solver_unit.sv
// ----------------------------------------------------------------------------
// quadratic_equation_solver_unit
// Real roots of a*x^2 + b*x + c = 0 over signed Q16.16 coefficients.
// ----------------------------------------------------------------------------
// Takes one equation per cycle and returns one result item per equation, in
// order. An item passes the front-end registers, the job queue, COEF_BITS+1
// square-root stages, 1 numerator stage, COEF_BITS+2+FRAC_BITS divider
// stages and the result register. The square-root and divider pipelines
// resolve one bit per stage; the rate stays one item per cycle while results
// are taken. A held result stalls the back end; the front end keeps taking
// items until the queue fills.
// epsilon is written through cfg_data and resets to 1.
`include "quadratic_equation_solver_unit_defines.svh"

module quadratic_equation_solver_unit #(
  parameter int FRAC_BITS  = qes_pkg::FRAC_BITS,
  parameter int FIFO_DEPTH = qes_pkg::FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  qes_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output qes_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qes_pkg::EPS_BITS-1:0]  cfg_data
);

  logic [qes_pkg::EPS_BITS-1:0] eps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= qes_pkg::EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_data;
    end
  end

  logic          job_push, fifo_full, job_pop, job_avail;
  qes_pkg::job_t push_job, pop_job;

  qes_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .eps       (eps_r),
    .q_full    (fifo_full),
    .job_valid (job_push),
    .job       (push_job)
  );

  qes_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (push_job),
    .full      (fifo_full),
    .pop       (job_pop),
    .pop_job   (pop_job),
    .not_empty (job_avail)
  );

  qes_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_avail),
    .job       (pop_job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  logic rootless_kind, single_kind, roots_zero;

  assign rootless_kind = (out_item.kind == qes_pkg::KIND_NONE) ||
                         (out_item.kind == qes_pkg::KIND_ANY) ||
                         (out_item.kind == qes_pkg::KIND_NEG_DISC);
  assign single_kind   = (out_item.kind == qes_pkg::KIND_LINEAR) ||
                         (out_item.kind == qes_pkg::KIND_DOUBLE);
  assign roots_zero    = (out_item.root_one == '0) && (out_item.root_two == '0) &&
                         !out_item.overflow;

  `QES_ASSERT_NOW(a_no_push_full, job_push, !fifo_full, "job pushed into full queue")
  `QES_ASSERT_NOW(a_no_pop_empty, job_pop, job_avail, "job popped from empty queue")
  `QES_ASSERT_NOW(a_no_root_zero, out_valid && rootless_kind, roots_zero, "rootless item carries roots")
  `QES_ASSERT_NOW(a_single_root, out_valid && single_kind, out_item.root_one == out_item.root_two, "roots differ")

endmodule
